// File: hdl/assert_macros.svh
// Assertion helpers for the receiver RTL.
// In synthesis both macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check that is switched off while reset is asserted.
`define SRR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that is also evaluated during reset.
`define SRR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SRR_ASSERT(label, clk, rst_n, prop, msg)
`define SRR_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: hdl/srr_pkg.sv
package srr_pkg;

    // Reorder buffer depth; must be a power of two so that the slot is the low seq bits.
    localparam int MAX_WINDOW = 16;
    localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W      = (SLOT_W > 3) ? SLOT_W : 3;

    // Field widths.
    localparam int SEQ_W    = 31;
    localparam int CHK_W    = 32;
    localparam int WIN_W    = 5;
    localparam int LOW_W    = 64;
    localparam int MID_W    = 64;
    localparam int HIGH_W   = 32;
    localparam int PAY_W    = LOW_W + MID_W + HIGH_W;
    localparam int WORD_W   = 32;
    localparam int SUM_WORDS = PAY_W / WORD_W;

    localparam int IN_TDATA_W  = 256;
    localparam int OUT_TDATA_W = 224;

    localparam logic [WIN_W-1:0] WIN_RESET    = 5'd8;
    localparam logic [SEQ_W-1:0] BASE_RESET   = 31'd1;
    localparam logic [CHK_W-1:0] ACK_BASE_SUM = 32'd980;

    localparam logic RESULT_ACK     = 1'b0;
    localparam logic RESULT_DELIVER = 1'b1;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_BYTES
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [CHK_W-1:0]  a;
        logic [CHK_W-1:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic [HIGH_W-1:0] high;
        logic [MID_W-1:0]  mid;
        logic [LOW_W-1:0]  low;
    } t_payload;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_payload          wdata;
        logic [SLOT_W-1:0] raddr;
    } t_buf_req;

    // Input tdata layout, first field in the low bits.
    typedef struct packed {
        logic [1:0]        pad;
        logic [HIGH_W-1:0] payload_high;
        logic [MID_W-1:0]  payload_mid;
        logic [LOW_W-1:0]  payload_low;
        logic [CHK_W-1:0]  packet_checksum;
        logic [SEQ_W-1:0]  ack_num;
        logic [SEQ_W-1:0]  seq_num;
    } t_in_data;

    // Output tdata layout, first field in the low bits.
    typedef struct packed {
        logic              pad;
        logic [HIGH_W-1:0] data_high;
        logic [MID_W-1:0]  data_mid;
        logic [LOW_W-1:0]  data_low;
        logic [CHK_W-1:0]  ack_checksum;
        logic [SEQ_W-1:0]  ack_number;
    } t_out_data;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_ADD_ACK,
        S_ADD_SEQ,
        S_AHEAD,
        S_BEHIND,
        S_ACK_SUM,
        S_ACK_OUT,
        S_DREAD,
        S_DOUT
    } t_state;

endpackage

// File: hdl/srr_alu.sv
module srr_alu import srr_pkg::*; (
    input  t_alu_req          i_req,
    output logic [CHK_W-1:0]  o_y
);

    logic [CHK_W-1:0] w_b0;
    logic [CHK_W-1:0] w_b1;
    logic [CHK_W-1:0] w_b2;
    logic [CHK_W-1:0] w_b3;

    // Sign-extended bytes of operand b for the byte accumulation.
    assign w_b0 = {{24{i_req.b[7]}},  i_req.b[7:0]};
    assign w_b1 = {{24{i_req.b[15]}}, i_req.b[15:8]};
    assign w_b2 = {{24{i_req.b[23]}}, i_req.b[23:16]};
    assign w_b3 = {{24{i_req.b[31]}}, i_req.b[31:24]};

    // Shared 32-bit adder with wraparound.
    always_comb begin
        case (i_req.op)
            ALU_ADD:   o_y = i_req.a + i_req.b;
            ALU_SUB:   o_y = i_req.a - i_req.b;
            ALU_BYTES: o_y = i_req.a + w_b0 + w_b1 + w_b2 + w_b3;
            default:   o_y = i_req.a;
        endcase
    end

endmodule

// File: hdl/srr_buf.sv
module srr_buf import srr_pkg::*; (
    input  logic     i_clk,
    input  t_buf_req i_req,
    output t_payload o_rdata
);

    t_payload r_mem [MAX_WINDOW];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

// File: hdl/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver.
// The slave stream carries one data packet per transaction (sequence and
// acknowledgement numbers, carried checksum, 20-byte payload). The master
// stream returns results: an ACK (tuser 0) and, for an in-order packet,
// the run of buffered payloads now ready for delivery (tuser 1). tlast
// marks the final result caused by one packet; a dropped packet gives none.
// The window register is written through i_cfg_we/i_cfg_wdata, by the user
// only while idle; the block does not enforce it. The checksum decision and
// then the window decision follow the arithmetic: the 20-byte sum goes
// through the shared adder four bytes a cycle, followed by single add and
// subtract steps on the same adder. A dropped packet frees the input at
// either decision; an ACK follows the window decision, and each delivery
// then passes through the registered read of the payload buffer. The input
// is ready again in the cycle after the last result is loaded into the
// output register. Reset sets the receive base to one, clears all received
// marks and sets the window to 8; buffer contents are not cleared. When the
// downstream side stalls, the held result stays in the output register and
// the sequencer waits until it is taken.
`include "assert_macros.svh"

module selective_repeat_receiver import srr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [WIN_W-1:0]        i_cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // seq_num, ack_num, packet_checksum, payload_low, payload_mid, payload_high, zero pad
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // ack_number, ack_checksum, data_low, data_mid, data_high, zero pad
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // result_kind
    output logic                    m_axis_tuser,
    output logic                    m_axis_tlast
);

    t_state                r_state, n_state;
    logic [SEQ_W-1:0]      r_seq, n_seq;
    logic [SEQ_W-1:0]      r_ack, n_ack;
    logic [CHK_W-1:0]      r_chk, n_chk;
    t_payload              r_pay, n_pay;
    logic [CHK_W-1:0]      r_acc, n_acc;
    logic [SEQ_W-1:0]      r_dist, n_dist;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_in_win, n_in_win;
    logic                  r_head, n_head;
    logic [SEQ_W-1:0]      r_base, n_base;
    logic [MAX_WINDOW-1:0] r_marks, n_marks;
    logic [WIN_W-1:0]      r_window, n_window;
    logic                  r_o_valid, n_o_valid;
    logic                  r_o_kind, n_o_kind;
    logic                  r_o_last, n_o_last;
    t_out_data             r_o_data, n_o_data;

    t_in_data              w_in;
    t_alu_req              w_alu_req;
    logic [CHK_W-1:0]      w_alu_y;
    t_buf_req              w_buf_req;
    t_payload              w_rdata;
    logic                  w_out_free;
    logic [WIN_W-1:0]      w_win;
    logic [SEQ_W-1:0]      w_win_ext;
    logic [SEQ_W-1:0]      w_behind;
    logic                  w_fwd;
    logic                  w_back;
    logic [SLOT_W-1:0]     w_seq_slot;
    logic [SLOT_W-1:0]     w_base_slot;
    logic                  w_last_dlv;
    logic [PAY_W-1:0]      w_pay_vec;

    assign w_in        = t_in_data'(s_axis_tdata);
    assign w_out_free  = !r_o_valid || m_axis_tready;
    assign w_seq_slot  = r_seq[SLOT_W-1:0];
    assign w_base_slot = r_base[SLOT_W-1:0];
    assign w_pay_vec   = r_pay;

    // Window clamped to the buffer depth.
    assign w_win     = (int'(r_window) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : r_window;
    assign w_win_ext = SEQ_W'(w_win);

    // Window tests on 31-bit modular distances.
    assign w_behind = w_alu_y[SEQ_W-1:0];
    assign w_fwd    = r_dist < w_win_ext;
    assign w_back   = (w_behind != '0) && (w_behind <= w_win_ext);

    // A delivery is the last one when the run limit is hit or the next slot is empty.
    assign w_last_dlv = (r_cnt == CNT_W'(MAX_WINDOW - 1)) || !r_marks[w_alu_y[SLOT_W-1:0]];

    srr_alu u_alu (
        .i_req (w_alu_req),
        .o_y   (w_alu_y)
    );

    srr_buf u_buf (
        .i_clk   (i_clk),
        .i_req   (w_buf_req),
        .o_rdata (w_rdata)
    );

    // Sequencer: next state, shared adder operands and result loading.
    always_comb begin
        n_state   = r_state;
        n_seq     = r_seq;
        n_ack     = r_ack;
        n_chk     = r_chk;
        n_pay     = r_pay;
        n_acc     = r_acc;
        n_dist    = r_dist;
        n_cnt     = r_cnt;
        n_in_win  = r_in_win;
        n_head    = r_head;
        n_base    = r_base;
        n_marks   = r_marks;
        n_window  = i_cfg_we ? i_cfg_wdata : r_window;
        n_o_valid = r_o_valid && !m_axis_tready;
        n_o_kind  = r_o_kind;
        n_o_last  = r_o_last;
        n_o_data  = r_o_data;

        w_alu_req.op = ALU_ADD;
        w_alu_req.a  = r_acc;
        w_alu_req.b  = '0;

        w_buf_req.we    = 1'b0;
        w_buf_req.waddr = w_seq_slot;
        w_buf_req.wdata = r_pay;
        w_buf_req.raddr = w_base_slot;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_seq      = w_in.seq_num;
                    n_ack      = w_in.ack_num;
                    n_chk      = w_in.packet_checksum;
                    n_pay.low  = w_in.payload_low;
                    n_pay.mid  = w_in.payload_mid;
                    n_pay.high = w_in.payload_high;
                    n_acc      = '0;
                    n_cnt      = '0;
                    n_state    = S_SUM;
                end
            end
            S_SUM: begin
                // Four payload bytes per cycle.
                w_alu_req.op = ALU_BYTES;
                w_alu_req.b  = w_pay_vec[WORD_W*r_cnt +: WORD_W];
                n_acc        = w_alu_y;
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SUM_WORDS - 1)) begin
                    n_state = S_ADD_ACK;
                end
            end
            S_ADD_ACK: begin
                w_alu_req.b = {1'b0, r_ack};
                n_acc       = w_alu_y;
                n_state     = S_ADD_SEQ;
            end
            S_ADD_SEQ: begin
                w_alu_req.b = {1'b0, r_seq};
                n_acc       = w_alu_y;
                n_state     = S_AHEAD;
            end
            S_AHEAD: begin
                // Checksum check, then distance ahead of the base.
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = {1'b0, r_seq};
                w_alu_req.b  = {1'b0, r_base};
                if (r_acc != r_chk) begin
                    n_state = S_IDLE;
                end else begin
                    n_dist  = w_alu_y[SEQ_W-1:0];
                    n_state = S_BEHIND;
                end
            end
            S_BEHIND: begin
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = {1'b0, r_base};
                w_alu_req.b  = {1'b0, r_seq};
                n_in_win     = w_fwd;
                n_head       = (r_dist == '0);
                n_state      = (w_fwd || w_back) ? S_ACK_SUM : S_IDLE;
            end
            S_ACK_SUM: begin
                w_alu_req.a = ACK_BASE_SUM;
                w_alu_req.b = {1'b0, r_seq};
                n_acc       = w_alu_y;
                n_state     = S_ACK_OUT;
            end
            S_ACK_OUT: begin
                if (w_out_free) begin
                    n_o_valid             = 1'b1;
                    n_o_kind              = RESULT_ACK;
                    n_o_last              = !(r_in_win && r_head);
                    n_o_data              = '0;
                    n_o_data.ack_number   = r_seq;
                    n_o_data.ack_checksum = r_acc;
                    if (r_in_win) begin
                        w_buf_req.we        = 1'b1;
                        n_marks[w_seq_slot] = 1'b1;
                    end
                    n_cnt   = '0;
                    n_state = (r_in_win && r_head) ? S_DREAD : S_IDLE;
                end
            end
            S_DREAD: begin
                // Buffer read of the base slot lands at the end of this cycle.
                n_state = S_DOUT;
            end
            S_DOUT: begin
                w_alu_req.a = {1'b0, r_base};
                w_alu_req.b = CHK_W'(1);
                if (w_out_free) begin
                    n_o_valid            = 1'b1;
                    n_o_kind             = RESULT_DELIVER;
                    n_o_last             = w_last_dlv;
                    n_o_data             = '0;
                    n_o_data.data_low    = w_rdata.low;
                    n_o_data.data_mid    = w_rdata.mid;
                    n_o_data.data_high   = w_rdata.high;
                    n_marks[w_base_slot] = 1'b0;
                    n_base               = w_alu_y[SEQ_W-1:0];
                    n_cnt                = r_cnt + CNT_W'(1);
                    n_state              = w_last_dlv ? S_IDLE : S_DREAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= BASE_RESET;
            r_marks   <= '0;
            r_window  <= WIN_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_base    <= n_base;
            r_marks   <= n_marks;
            r_window  <= n_window;
            r_o_valid <= n_o_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_seq    <= n_seq;
        r_ack    <= n_ack;
        r_chk    <= n_chk;
        r_pay    <= n_pay;
        r_acc    <= n_acc;
        r_dist   <= n_dist;
        r_cnt    <= n_cnt;
        r_in_win <= n_in_win;
        r_head   <= n_head;
        r_o_kind <= n_o_kind;
        r_o_last <= n_o_last;
        r_o_data <= n_o_data;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;

    // The sequencer takes one packet at a time.
    `SRR_ASSERT(a_one_packet, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while a packet is in progress")
    // A delivery run only visits slots that hold a received payload.
    `SRR_ASSERT(a_dlv_marked, i_clk, i_rst_n, (r_state == S_DREAD || r_state == S_DOUT) |-> r_marks[w_base_slot], "delivery from an empty slot")
    // Each delivered payload advances the base by exactly one.
    `SRR_ASSERT(a_base_step, i_clk, i_rst_n, (r_state == S_DOUT && w_out_free) |=> (r_base == SEQ_W'($past(r_base) + SEQ_W'(1))), "base did not advance by one on delivery")

endmodule

// File: sim/selective_repeat_receiver_tb.sv
module selective_repeat_receiver_tb;
    import srr_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int NUM_ROWS       = 22;
    localparam int NUM_SEGMENTS   = 7;

    // Window setting and packet count for each random segment.
    localparam int SEG_WINDOW [NUM_SEGMENTS] = '{16, 3, 31, 1, 0, 12, 16};
    localparam int SEG_ITEMS  [NUM_SEGMENTS] = '{60, 45, 55, 40, 15, 50, 45};

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_DROP,
        ROW_ACK,
        ROW_ACK_DELIVER
    } row_outcome_e;

    typedef enum logic [1:0] {
        CHK_GOOD,
        CHK_BAD,
        CHK_FIXED
    } chk_mode_e;

    typedef enum int {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL
    } pace_e;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  ack;
        chk_mode_e         chk_mode;
        logic [CHK_W-1:0]  chk;
        logic [LOW_W-1:0]  low;
        logic [MID_W-1:0]  mid;
        logic [HIGH_W-1:0] high;
        row_outcome_e      outcome;
    } stim_row_t;

    typedef struct packed {
        logic      kind;
        logic      last;
        t_out_data body;
    } srr_result_t;

    // Directed packets, starting from reset with a window of 8.
    localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
        '{31'd1, 31'd0, CHK_GOOD, 32'd0, 64'd0, 64'd0, 32'd0, ROW_ACK_DELIVER},
        '{31'd2, 31'h7FFF_FFFF, CHK_GOOD, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, ROW_ACK_DELIVER},
        '{31'd3, 31'h1234, CHK_BAD, 32'd0, 64'h0123_4567_89AB_CDEF,
          64'hFEDC_BA98_7654_3210, 32'hDEAD_BEEF, ROW_DROP},
        '{31'd3, 31'd0, CHK_GOOD, 32'd0, 64'h8080_8080_8080_8080,
          64'h8080_8080_8080_8080, 32'h8080_8080, ROW_ACK_DELIVER},
        '{31'd2, 31'h42, CHK_GOOD, 32'd0, 64'h1111_2222_3333_4444,
          64'h5555_6666_7777_8888, 32'h9999_AAAA, ROW_ACK},
        '{31'h7FFF_FFFF, 31'h5555_5555, CHK_GOOD, 32'd0, 64'h7F7F_7F7F_7F7F_7F7F,
          64'h7F7F_7F7F_7F7F_7F7F, 32'h7F7F_7F7F, ROW_ACK},
        '{31'd6, 31'h2AAA_AAAA, CHK_GOOD, 32'd0, 64'hA5A5_0F0F_C3C3_1E1E,
          64'h0001_0203_0405_0607, 32'h0809_0A0B, ROW_ACK},
        '{31'd5, 31'h100, CHK_GOOD, 32'd0, 64'h1020_3040_5060_7080,
          64'h90A0_B0C0_D0E0_F000, 32'h0BAD_F00D, ROW_ACK},
        '{31'd6, 31'h101, CHK_GOOD, 32'd0, 64'hCAFE_BABE_0000_FFFF,
          64'h1357_9BDF_2468_ACE0, 32'h7654_3210, ROW_ACK},
        '{31'd4, 31'h102, CHK_GOOD, 32'd0, 64'h0F1E_2D3C_4B5A_6978,
          64'h8796_A5B4_C3D2_E1F0, 32'h55AA_55AA, ROW_PREDICT},
        '{31'd15, 31'd0, CHK_GOOD, 32'd0, 64'h0000_0000_0000_0001,
          64'h8000_0000_0000_0000, 32'h0000_0100, ROW_DROP},
        '{31'd14, 31'h77, CHK_GOOD, 32'd0, 64'h3C3C_3C3C_C3C3_C3C3,
          64'h6996_9669_6996_9669, 32'hF00F_0FF0, ROW_ACK},
        '{31'h7FFF_FFFE, 31'd0, CHK_GOOD, 32'd0, 64'd0, 64'd0, 32'd0, ROW_DROP},
        '{31'd0, 31'd0, CHK_GOOD, 32'd0, 64'h0102_0408_1020_4080,
          64'hFEFD_FBF7_EFDF_BF7F, 32'h1248_8421, ROW_ACK},
        '{31'd1, 31'h7FFF_FFFF, CHK_FIXED, 32'h8000_0000, 64'd0, 64'd0, 32'd0,
          ROW_ACK},
        '{31'd8, 31'h7FFF_FFF7, CHK_FIXED, 32'h7FFF_FFFF, 64'd0, 64'd0, 32'd0,
          ROW_ACK},
        '{31'd9, 31'h7FFF_FFFF, CHK_BAD, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, ROW_DROP},
        '{31'h4000_0000, 31'd3, CHK_GOOD, 32'd0, 64'h2222_4444_8888_1111,
          64'h3333_6666_CCCC_9999, 32'h7777_EEEE, ROW_DROP},
        '{31'd7, 31'h10, CHK_GOOD, 32'd0, 64'hBEEF_0001_BEEF_0002,
          64'hBEEF_0003_BEEF_0004, 32'hBEEF_0005, ROW_PREDICT},
        '{31'd10, 31'h11, CHK_GOOD, 32'd0, 64'h0A0A_0A0A_0A0A_0A0A,
          64'hA0A0_A0A0_A0A0_A0A0, 32'h0A0A_A0A0, ROW_ACK},
        '{31'd9, 31'h12, CHK_GOOD, 32'd0, 64'h0909_0909_9090_9090,
          64'h9999_0000_9999_0000, 32'h0990_0990, ROW_PREDICT},
        '{31'd11, 31'd8, CHK_FIXED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, ROW_ACK_DELIVER}
    };

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [WIN_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // seq_num, ack_num, packet_checksum, payload_low, payload_mid, payload_high, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // ack_number, ack_checksum, data_low, data_mid, data_high, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // result_kind
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    // Receiver state as the testbench sees it.
    logic [WIN_W-1:0] win_reg = WIN_RESET;
    logic [SEQ_W-1:0] model_base = BASE_RESET;
    logic             slot_marked [MAX_WINDOW];
    t_payload         slot_payload [MAX_WINDOW];

    // Results the block owes, oldest first, and those of the latest packet.
    srr_result_t      owed_results [$];
    srr_result_t      fresh_results [$];
    logic [SEQ_W-1:0] burst_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int failures = 0;
    int packets_sent = 0;
    int drops = 0;
    int acks_seen = 0;
    int deliveries_seen = 0;
    int run_len = 0;
    int longest_run = 0;
    int windows_tried = 0;

    selective_repeat_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("status: fail");
        $finish;
    end

    // Packet checksum: signed payload bytes plus both numbers, modulo 2^32.
    function automatic logic [CHK_W-1:0] packet_sum(input t_in_data pkt);
        logic [PAY_W-1:0] bytes;
        logic [CHK_W-1:0] acc;
        bytes = {pkt.payload_high, pkt.payload_mid, pkt.payload_low};
        acc = 32'(pkt.seq_num) + 32'(pkt.ack_num);
        for (int i = 0; i < PAY_W / 8; i++) begin
            acc = acc + {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
        end
        return acc;
    endfunction

    function automatic int open_window();
        return (win_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_reg);
    endfunction

    function automatic srr_result_t ack_result(input logic [SEQ_W-1:0] seq);
        srr_result_t r;
        r = '0;
        r.kind = RESULT_ACK;
        r.body.ack_number = seq;
        r.body.ack_checksum = ACK_BASE_SUM + 32'(seq);
        return r;
    endfunction

    function automatic srr_result_t delivery_result(input t_payload pl);
        srr_result_t r;
        r = '0;
        r.kind = RESULT_DELIVER;
        r.body.data_low = pl.low;
        r.body.data_mid = pl.mid;
        r.body.data_high = pl.high;
        return r;
    endfunction

    // Works out the ACK and the in-order deliveries that one packet causes,
    // and advances the receive window.
    function automatic void ack_and_deliver(input t_in_data pkt);
        logic [SEQ_W-1:0]  ahead;
        logic [SEQ_W-1:0]  behind;
        logic [SLOT_W-1:0] slot;
        logic              chk_ok;
        int                w;
        fresh_results.delete();
        w = open_window();
        chk_ok = (packet_sum(pkt) == pkt.packet_checksum);
        ahead = pkt.seq_num - model_base;
        behind = model_base - pkt.seq_num;
        if (chk_ok && ahead < w) begin
            slot = pkt.seq_num[SLOT_W-1:0];
            fresh_results.push_back(ack_result(pkt.seq_num));
            slot_payload[slot] = {pkt.payload_high, pkt.payload_mid, pkt.payload_low};
            slot_marked[slot] = 1'b1;
            // An in-order packet releases the contiguous run of stored payloads.
            if (ahead == 0) begin
                for (int cnt = 0; cnt < MAX_WINDOW; cnt++) begin
                    slot = model_base[SLOT_W-1:0];
                    if (!slot_marked[slot]) break;
                    fresh_results.push_back(delivery_result(slot_payload[slot]));
                    slot_marked[slot] = 1'b0;
                    model_base = model_base + 1'b1;
                end
            end
        end else if (chk_ok && behind >= 1 && behind <= w) begin
            fresh_results.push_back(ack_result(pkt.seq_num));
        end
        if (fresh_results.size() == 0) begin
            drops++;
        end else begin
            fresh_results[fresh_results.size() - 1].last = 1'b1;
        end
    endfunction

    // Random packet: mostly good packets around the window, including shuffled
    // bursts that end with the base so that long delivery runs occur.
    function automatic t_in_data random_packet();
        t_in_data         pkt;
        logic [SEQ_W-1:0] seq;
        logic             chk_good;
        logic             wild;
        int               w;
        int               k;
        int               r;
        int               tmp;
        int               pick;
        int               flavor;
        int               offs [MAX_WINDOW];
        pkt = '0;
        w = open_window();
        chk_good = 1'b1;
        wild = 1'b0;
        if (burst_q.size() == 0 && w != 0 && $urandom_range(99) < 25) begin
            k = $urandom_range(w, 1);
            for (int j = 0; j < k - 1; j++) offs[j] = j + 1;
            for (int j = k - 2; j > 0; j--) begin
                r = $urandom_range(j);
                tmp = offs[j];
                offs[j] = offs[r];
                offs[r] = tmp;
            end
            for (int j = 0; j < k - 1; j++) burst_q.push_back(model_base + 31'(offs[j]));
            burst_q.push_back(model_base);
        end
        pick = $urandom_range(99);
        if (burst_q.size() != 0 && pick >= 10) begin
            seq = burst_q.pop_front();
        end else if (pick < 30) begin
            seq = model_base + 31'((w == 0) ? 0 : $urandom_range(w - 1));
        end else if (pick < 48) begin
            seq = model_base - 31'($urandom_range(w + 1, 1));
        end else if (pick < 60) begin
            seq = model_base + 31'(w + $urandom_range(3));
        end else if (pick < 80) begin
            seq = model_base + 31'($urandom_range(20)) - 31'd4;
            chk_good = 1'b0;
        end else begin
            seq = 31'($urandom);
            chk_good = 1'($urandom_range(1));
            wild = 1'b1;
        end
        pkt.seq_num = seq;
        pkt.ack_num = 31'($urandom);
        flavor = $urandom_range(99);
        if (flavor < 5) begin
            pkt.payload_low = '1;
            pkt.payload_mid = '1;
            pkt.payload_high = '1;
        end else if (flavor < 9) begin
            pkt.payload_low = {8{8'h80}};
            pkt.payload_mid = {8{8'h80}};
            pkt.payload_high = {4{8'h80}};
        end else if (flavor >= 12) begin
            pkt.payload_low = {$urandom, $urandom};
            pkt.payload_mid = {$urandom, $urandom};
            pkt.payload_high = $urandom;
        end
        if (chk_good) begin
            pkt.packet_checksum = packet_sum(pkt);
        end else if (wild) begin
            pkt.packet_checksum = $urandom;
        end else if ($urandom_range(1) == 1) begin
            pkt.packet_checksum = packet_sum(pkt) ^ (32'd1 << $urandom_range(31));
        end else begin
            pkt.packet_checksum = packet_sum(pkt) - 32'($urandom_range(1000, 1));
        end
        return pkt;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            failures++;
        end
    endfunction

    // Offers one packet, idling first as the current pacing asks, and returns
    // at the edge where the transaction completes.
    task automatic send_packet(input t_in_data pkt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pkt;
        do @(posedge i_clk); while (!s_axis_tready);
        packets_sent++;
    endtask

    // Holds the sender off until every owed result has arrived, then lets
    // a dropped packet that is still in flight finish.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(input int w);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= WIN_W'(w);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_reg = WIN_W'(w);
        burst_q.delete();
        windows_tried++;
    endtask

    task automatic set_pace(input pace_e pace);
        case (pace)
            PACE_SLOW_SINK: begin
                send_idle_pct = 31;
                recv_idle_pct = 72;
            end
            PACE_SLOW_SOURCE: begin
                send_idle_pct = 72;
                recv_idle_pct = 31;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Result side: random backpressure and in-order comparison of each
    // completed transaction with the oldest owed result.
    always @(posedge i_clk) begin : result_sink
        t_out_data   got;
        srr_result_t want;
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (owed_results.size() == 0) begin
                $error("unexpected result: kind %b, tdata %h", m_axis_tuser, m_axis_tdata);
                failures++;
            end else begin
                want = owed_results.pop_front();
                check_field("result_kind", 64'(want.kind), 64'(m_axis_tuser));
                check_field("ack_number", 64'(want.body.ack_number), 64'(got.ack_number));
                check_field("ack_checksum", 64'(want.body.ack_checksum),
                            64'(got.ack_checksum));
                check_field("data_low", want.body.data_low, got.data_low);
                check_field("data_mid", want.body.data_mid, got.data_mid);
                check_field("data_high", 64'(want.body.data_high), 64'(got.data_high));
                check_field("last_result", 64'(want.last), 64'(m_axis_tlast));
            end
            if (m_axis_tuser == RESULT_DELIVER) begin
                deliveries_seen++;
                run_len++;
                if (run_len > longest_run) longest_run = run_len;
            end else begin
                acks_seen++;
            end
            if (m_axis_tlast) run_len = 0;
        end
    end

    initial begin : stimulus
        stim_row_t   row;
        t_in_data    pkt;
        srr_result_t want;
        for (int i = 0; i < MAX_WINDOW; i++) slot_marked[i] = 1'b0;
        set_pace(PACE_SLOW_SINK);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed packets; simple rows carry their expected results.
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = STIM_ROWS[i];
            pkt = '0;
            pkt.seq_num = row.seq;
            pkt.ack_num = row.ack;
            pkt.payload_low = row.low;
            pkt.payload_mid = row.mid;
            pkt.payload_high = row.high;
            case (row.chk_mode)
                CHK_GOOD:  pkt.packet_checksum = packet_sum(pkt);
                CHK_BAD:   pkt.packet_checksum = packet_sum(pkt) ^ 32'd1;
                default:   pkt.packet_checksum = row.chk;
            endcase
            send_packet(pkt);
            ack_and_deliver(pkt);
            case (row.outcome)
                ROW_PREDICT: begin
                    foreach (fresh_results[k]) owed_results.push_back(fresh_results[k]);
                end
                ROW_ACK: begin
                    want = ack_result(row.seq);
                    want.last = 1'b1;
                    owed_results.push_back(want);
                end
                ROW_ACK_DELIVER: begin
                    owed_results.push_back(ack_result(row.seq));
                    want = delivery_result({row.high, row.mid, row.low});
                    want.last = 1'b1;
                    owed_results.push_back(want);
                end
                default: begin
                end
            endcase
        end

        // Random segments, each under its window setting and one of three pacings.
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            set_window(SEG_WINDOW[seg]);
            if (seg < 2) begin
                set_pace(PACE_SLOW_SINK);
            end else if (seg < 4) begin
                set_pace(PACE_SLOW_SOURCE);
            end else begin
                set_pace(PACE_FULL);
            end
            for (int n = 0; n < SEG_ITEMS[seg]; n++) begin
                pkt = random_packet();
                send_packet(pkt);
                ack_and_deliver(pkt);
                foreach (fresh_results[k]) owed_results.push_back(fresh_results[k]);
            end
        end
        drain();

        $display("Sent %0d packets (%0d dropped) under %0d window settings after reset.",
                 packets_sent, drops, windows_tried);
        $display("Checked %0d ACKs and %0d deliveries; longest in-order run %0d.",
                 acks_seen, deliveries_seen, longest_run);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
